FILE: rtl/core/ipd_pkg.sv
// Shared types and constants of the infrared pulse-distance decoder.
package ipd_pkg;

  localparam int DUR_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int TOL_W     = 7;
  localparam int EXC_W     = 16;
  localparam int LEN_W     = 7;
  localparam int DATA_W    = 64;
  localparam int LO_W      = 17;
  localparam int HI_W      = 18;
  localparam int NUM_BND   = 9;
  localparam int MID_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER,
    REG_ONE,
    REG_ZERO,
    REG_FOOTER,
    REG_TOLERANCE,
    REG_EXCESS,
    REG_FRAME_BITS,
    REG_MODE
  } reg_idx_t;

  // Timing windows kept in the bound tables.
  typedef enum logic [3:0] {
    BND_HDR_MARK,
    BND_HDR_SPACE,
    BND_ONE_MARK,
    BND_ONE_SPACE,
    BND_ZERO_MARK,
    BND_ZERO_SPACE,
    BND_FOOT_MARK,
    BND_FOOT_SPACE,
    BND_FOOT_LEAST
  } bnd_idx_t;

  typedef logic [NUM_BND-1:0][LO_W-1:0] bnd_lo_t;
  typedef logic [NUM_BND-1:0][HI_W-1:0] bnd_hi_t;

  // Settings the sequencer needs, derived from the configuration registers.
  typedef struct packed {
    logic             hdr_mark_en;
    logic             hdr_space_en;
    logic             foot_mark_en;
    logic             foot_space_en;
    logic             msb_first;
    logic             foot_least;
    logic             single;
    logic             last_space;
    logic [LEN_W-1:0] frame_len;
  } cfg_t;

  // One classified duration, as it travels from the front end to the back end.
  typedef struct packed {
    logic is_mark;
    logic eoc;
    logic hdr_mark_ok;
    logic hdr_space_ok;
    logic one_mark_ok;
    logic one_space_ok;
    logic zero_mark_ok;
    logic zero_space_ok;
    logic foot_mark_ok;
    logic foot_space_ok;
    logic foot_least_ok;
  } class_t;

  typedef struct packed {
    logic [DATA_W-1:0] frame_data;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

FILE: rtl/core/ipd_fifo.sv
// Small first-word-fall-through register queue.
module ipd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/core/ipd_cfg_bounds.sv
// Configuration registers and the sequencer that precomputes the timing windows.
module ipd_cfg_bounds
  import ipd_pkg::*;
#(
  parameter int MAX_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg,
  output bnd_lo_t              bnd_lo,
  output bnd_hi_t              bnd_hi,
  output logic                 busy
);

  localparam int JOBS = 2 * NUM_BND;
  localparam int JW   = $clog2(JOBS + 1);
  localparam logic [25:0] RECIP_100 = 26'd42949673;

  logic [CFG_W-1:0] header_timing;
  logic [CFG_W-1:0] one_timing;
  logic [CFG_W-1:0] zero_timing;
  logic [CFG_W-1:0] footer_timing;
  logic [TOL_W-1:0] tolerance;
  logic [EXC_W-1:0] excess;
  logic [LEN_W-1:0] frame_bits;
  logic [3:0]       mode;

  logic [JW-1:0]        job;
  logic                 issue;
  logic                 s1_valid;
  logic [3:0]           s1_entry;
  logic                 s1_hi;
  logic signed [26:0]   s1_prod;

  logic [DUR_W-1:0]     tim;
  logic                 kind_mark;
  logic                 kind_least;
  logic signed [17:0]   d_mark;
  logic signed [17:0]   d_space;
  logic signed [17:0]   d_sel;
  logic [LO_W-1:0]      base;
  logic signed [8:0]    factor;
  logic signed [26:0]   prod;
  logic signed [26:0]   exc100;
  logic [3:0]           entry;
  logic [50:0]          quot_full;
  logic [18:0]          quot;
  logic                 pos;

  // Derived settings.
  always_comb begin
    cfg.hdr_mark_en   = (header_timing[31:16] != '0);
    cfg.hdr_space_en  = (header_timing[15:0] != '0);
    cfg.foot_mark_en  = (footer_timing[31:16] != '0);
    cfg.foot_space_en = (footer_timing[15:0] != '0);
    cfg.msb_first     = mode[0];
    cfg.foot_least    = mode[1];
    cfg.single        = mode[2];
    cfg.last_space    = !mode[3] && ((footer_timing[31:16] != '0) ||
                                     (one_timing[15:0] != zero_timing[15:0]));
    if (frame_bits == '0) begin
      cfg.frame_len = LEN_W'(1);
    end else if (frame_bits > LEN_W'(MAX_BITS)) begin
      cfg.frame_len = LEN_W'(MAX_BITS);
    end else begin
      cfg.frame_len = frame_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_timing <= '0;
      one_timing    <= '0;
      zero_timing   <= '0;
      footer_timing <= '0;
      tolerance     <= TOL_W'(25);
      excess        <= '0;
      frame_bits    <= LEN_W'(32);
      mode          <= 4'd1;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_HEADER:     header_timing <= cfg_data;
        REG_ONE:        one_timing    <= cfg_data;
        REG_ZERO:       zero_timing   <= cfg_data;
        REG_FOOTER:     footer_timing <= cfg_data;
        REG_TOLERANCE:  tolerance     <= cfg_data[TOL_W-1:0];
        REG_EXCESS:     excess        <= cfg_data[EXC_W-1:0];
        REG_FRAME_BITS: frame_bits    <= cfg_data[LEN_W-1:0];
        REG_MODE:       mode          <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Stage 0: pick the desired time of one window and scale it by the tolerance.
  assign issue = busy && (job != JW'(JOBS));
  assign entry = job[4:1];

  always_comb begin
    tim        = '0;
    kind_mark  = 1'b0;
    kind_least = 1'b0;
    case (bnd_idx_t'(entry))
      BND_HDR_MARK:   begin tim = header_timing[31:16]; kind_mark = 1'b1; end
      BND_HDR_SPACE:  tim = header_timing[15:0];
      BND_ONE_MARK:   begin tim = one_timing[31:16]; kind_mark = 1'b1; end
      BND_ONE_SPACE:  tim = one_timing[15:0];
      BND_ZERO_MARK:  begin tim = zero_timing[31:16]; kind_mark = 1'b1; end
      BND_ZERO_SPACE: tim = zero_timing[15:0];
      BND_FOOT_MARK:  begin tim = footer_timing[31:16]; kind_mark = 1'b1; end
      BND_FOOT_SPACE: tim = footer_timing[15:0];
      default:        begin tim = footer_timing[15:0]; kind_least = 1'b1; end
    endcase

    d_mark  = $signed({2'b00, tim}) + $signed({{2{excess[EXC_W-1]}}, excess});
    d_space = $signed({2'b00, tim}) - $signed({{2{excess[EXC_W-1]}}, excess});
    d_sel   = kind_mark ? d_mark : d_space;

    if (kind_least) begin
      base = {1'b0, tim};
    end else if (d_sel[17]) begin
      base = '0;
    end else begin
      base = d_sel[LO_W-1:0];
    end

    if (job[0]) begin
      factor = $signed({2'b00, tolerance}) + 9'sd100;
    end else begin
      factor = 9'sd100 - $signed({2'b00, tolerance});
    end

    exc100 = $signed({{11{excess[EXC_W-1]}}, excess}) * 27'sd100;
    prod   = $signed({10'b0, base}) * $signed({{18{factor[8]}}, factor});
    if (kind_least && !job[0]) begin
      prod = prod - exc100;
    end
  end

  // Stage 1: floor division by 100 through a reciprocal multiply.
  always_comb begin
    pos       = !s1_prod[26] && (s1_prod != '0);
    quot_full = {26'b0, s1_prod[24:0]} * {25'b0, RECIP_100};
    quot      = quot_full[50:32];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      busy     <= 1'b1;
      job      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        job <= job + 1'b1;
      end
      if (s1_valid && (s1_entry == 4'(NUM_BND - 1)) && s1_hi) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_entry <= entry;
      s1_hi    <= job[0];
      s1_prod  <= prod;
    end
    if (s1_valid) begin
      if (s1_hi) begin
        bnd_hi[s1_entry] <= quot[HI_W-1:0] + 1'b1;
      end else begin
        bnd_lo[s1_entry] <= pos ? quot[LO_W-1:0] : '0;
      end
    end
  end

endmodule

FILE: rtl/core/ipd_front.sv
// Front end: accepts durations, checks them against every window, queues the result.
module ipd_front
  import ipd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [DUR_W-1:0] duration,
  input  logic             is_mark,
  input  logic             end_of_capture,
  input  logic             busy,
  input  bnd_lo_t          bnd_lo,
  input  bnd_hi_t          bnd_hi,
  input  logic             cls_pop,
  output class_t           cls,
  output logic             cls_empty
);

  logic [NUM_BND-1:0] win_ok;
  logic [NUM_BND-1:0] lo_ok;
  class_t             cls_in;
  logic               q_full;

  always_comb begin
    for (int i = 0; i < NUM_BND; i++) begin
      lo_ok[i]  = ({1'b0, duration} >= bnd_lo[i]);
      win_ok[i] = lo_ok[i] && ({2'b00, duration} <= bnd_hi[i]);
    end
    cls_in.is_mark       = is_mark;
    cls_in.eoc           = end_of_capture;
    cls_in.hdr_mark_ok   = win_ok[BND_HDR_MARK];
    cls_in.hdr_space_ok  = win_ok[BND_HDR_SPACE];
    cls_in.one_mark_ok   = win_ok[BND_ONE_MARK];
    cls_in.one_space_ok  = win_ok[BND_ONE_SPACE];
    cls_in.zero_mark_ok  = win_ok[BND_ZERO_MARK];
    cls_in.zero_space_ok = win_ok[BND_ZERO_SPACE];
    cls_in.foot_mark_ok  = win_ok[BND_FOOT_MARK];
    cls_in.foot_space_ok = win_ok[BND_FOOT_SPACE];
    cls_in.foot_least_ok = (duration == '0) || lo_ok[BND_FOOT_LEAST];
  end

  // Inputs are held off while the windows are being recomputed.
  assign full = rst || busy || q_full;

  ipd_fifo #(
    .WIDTH($bits(class_t)),
    .DEPTH(MID_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full),
    .din   (cls_in),
    .full  (q_full),
    .pop   (cls_pop),
    .dout  (cls),
    .empty (cls_empty)
  );

endmodule

FILE: rtl/core/ipd_back.sv
// Back end: frame sequencer that walks header, data bits and footer.
module ipd_back
  import ipd_pkg::*;
#(
  parameter int MAX_BITS = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    busy,
  input  cfg_t    cfg,
  input  class_t  cls,
  input  logic    cls_empty,
  output logic    cls_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res_data
);

  localparam int IW = $clog2(MAX_BITS);

  typedef enum logic [2:0] {
    PH_HDR_MARK,
    PH_HDR_SPACE,
    PH_DATA_MARK,
    PH_DATA_SPACE,
    PH_FOOT_MARK,
    PH_FOOT_SPACE
  } phase_t;

  typedef enum logic [1:0] {
    R_FAIL,
    R_CONT,
    R_DONE
  } code_t;

  typedef struct packed {
    code_t               code;
    phase_t              ph;
    logic [LEN_W-1:0]    bd;
    logic [1:0]          mc;
    logic [MAX_BITS-1:0] sd;
  } step_t;

  phase_t              phase;
  logic [LEN_W-1:0]    bits_done;
  logic [1:0]          mark_class;
  logic [MAX_BITS-1:0] shift_data;

  phase_t              hunt_ph;
  step_t               first;
  step_t               second;
  step_t               res;
  logic                retry;
  logic                proc;
  logic                emit;
  logic                keep;

  function automatic step_t eval(input phase_t ph, input logic [LEN_W-1:0] bd,
                                 input logic [1:0] mc, input logic [MAX_BITS-1:0] sd,
                                 input class_t c, input cfg_t g);
    step_t    s;
    logic     lastmark;
    logic     want_mark;
    logic     use_mark;
    logic     m1;
    logic     m0;
    logic     took;
    logic     bit_v;
    logic     go_data;
    logic     go_foot;
    logic [1:0] cl;
    s.code    = R_FAIL;
    s.ph      = ph;
    s.bd      = bd;
    s.mc      = mc;
    s.sd      = sd;
    lastmark  = (bd + 1'b1 == g.frame_len) && !g.last_space;
    took      = 1'b0;
    bit_v     = 1'b0;
    go_data   = 1'b0;
    go_foot   = 1'b0;
    want_mark = !bd[0];
    use_mark  = want_mark || lastmark;
    m1        = 1'b0;
    m0        = 1'b0;
    cl        = {c.zero_mark_ok, c.one_mark_ok};
    case (ph)
      PH_HDR_MARK: begin
        if (c.is_mark && c.hdr_mark_ok) begin
          s.code = R_CONT;
          s.ph   = g.hdr_space_en ? PH_HDR_SPACE : PH_DATA_MARK;
        end
      end
      PH_HDR_SPACE: begin
        if (!c.is_mark && c.hdr_space_ok) begin
          s.code = R_CONT;
          s.ph   = PH_DATA_MARK;
        end
      end
      PH_DATA_MARK: begin
        if (g.single) begin
          m1 = use_mark ? c.one_mark_ok : c.one_space_ok;
          m0 = use_mark ? c.zero_mark_ok : c.zero_space_ok;
          if ((c.is_mark == want_mark) && (m1 || m0)) begin
            took  = 1'b1;
            bit_v = m1;
          end
        end else if (c.is_mark && (cl != 2'b00)) begin
          if (lastmark) begin
            took  = 1'b1;
            bit_v = cl[0];
          end else begin
            s.code = R_CONT;
            s.mc   = cl;
            s.ph   = PH_DATA_SPACE;
          end
        end
      end
      PH_DATA_SPACE: begin
        m1 = mc[0] && c.one_space_ok;
        m0 = mc[1] && c.zero_space_ok;
        if (!c.is_mark && (m1 || m0)) begin
          took  = 1'b1;
          bit_v = m1;
          s.mc  = 2'b00;
        end
      end
      PH_FOOT_MARK: begin
        if (c.is_mark && c.foot_mark_ok) begin
          go_foot = 1'b1;
        end
      end
      PH_FOOT_SPACE: begin
        if (!c.is_mark && (g.foot_least ? c.foot_least_ok : c.foot_space_ok)) begin
          s.code = R_DONE;
        end
      end
      default: s.code = R_FAIL;
    endcase

    if (took) begin
      if (g.msb_first) begin
        s.sd = {sd[MAX_BITS-2:0], bit_v};
      end else begin
        s.sd = sd | (MAX_BITS'(bit_v) << bd[IW-1:0]);
      end
      s.bd = bd + 1'b1;
      if (s.bd >= g.frame_len) begin
        go_data = 1'b1;
      end else begin
        s.code = R_CONT;
        s.ph   = PH_DATA_MARK;
      end
    end
    if (go_data) begin
      if (g.foot_mark_en) begin
        s.code = R_CONT;
        s.ph   = PH_FOOT_MARK;
      end else begin
        go_foot = 1'b1;
      end
    end
    if (go_foot) begin
      if (g.foot_space_en && !c.eoc) begin
        s.code = R_CONT;
        s.ph   = PH_FOOT_SPACE;
      end else begin
        s.code = R_DONE;
      end
    end
    return s;
  endfunction

  always_comb begin
    if (cfg.hdr_mark_en) begin
      hunt_ph = PH_HDR_MARK;
    end else if (cfg.hdr_space_en) begin
      hunt_ph = PH_HDR_SPACE;
    end else begin
      hunt_ph = PH_DATA_MARK;
    end

    first  = eval(phase, bits_done, mark_class, shift_data, cls, cfg);
    second = eval(hunt_ph, '0, 2'b00, '0, cls, cfg);
    // A mark that broke a frame gets one more look as the start of a new one.
    retry  = cls.is_mark && !((phase == hunt_ph) && (bits_done == '0));
    res    = (first.code == R_FAIL && retry) ? second : first;

    proc     = !busy && !cls_empty && !res_full;
    emit     = (res.code == R_DONE);
    keep     = (res.code == R_CONT) && !cls.eoc;
    cls_pop  = proc;
    res_push = proc && emit;
    res_data.frame_data   = DATA_W'(res.sd);
    res_data.frame_length = cfg.frame_len;
  end

  always_ff @(posedge clk) begin
    if (rst || busy || (proc && !keep)) begin
      phase      <= hunt_ph;
      bits_done  <= '0;
      mark_class <= 2'b00;
      shift_data <= '0;
    end else if (proc) begin
      phase      <= res.ph;
      bits_done  <= res.bd;
      mark_class <= res.mc;
      shift_data <= res.sd;
    end
  end

endmodule

FILE: rtl/core/ir_pulse_distance_decoder.sv
// Top level of the infrared pulse-distance decoder.
//
//  Channel   Handshake            Payload
//  input     push / full          duration[15:0], is_mark, end_of_capture
//  result    empty / pop          frame_data[63:0], frame_length[6:0]
//  config    cfg_write            cfg_index[2:0], cfg_data[31:0]
//
// One duration is taken every clock cycle while full is low. A transfer on the
// input side is classified in the same cycle and queued for the frame sequencer,
// and each frame result passes through the result queue before it shows on the
// result ports.
// After reset and after every configuration write, full stays high while the
// 18 window bounds are rebuilt through a two-stage multiplier pipeline.
// Reset is synchronous and active high. A stalled result queue fills the small
// queue between the front end and the sequencer before full is raised.
module ir_pulse_distance_decoder
  import ipd_pkg::*;
#(
  parameter int MAX_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [DUR_W-1:0]     duration,
  input  logic                 is_mark,
  input  logic                 end_of_capture,
  output logic                 empty,
  input  logic                 pop,
  output logic [DATA_W-1:0]    frame_data,
  output logic [LEN_W-1:0]     frame_length,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  bnd_lo_t bnd_lo;
  bnd_hi_t bnd_hi;
  logic    busy;
  class_t  cls;
  logic    cls_empty;
  logic    cls_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  // Configuration registers plus the precomputed mark and space windows.
  ipd_cfg_bounds #(
    .MAX_BITS(MAX_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .bnd_lo    (bnd_lo),
    .bnd_hi    (bnd_hi),
    .busy      (busy)
  );

  // The front end compares each duration against all windows at once and
  // queues the match flags, so the sequencer never touches the arithmetic.
  ipd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .duration       (duration),
    .is_mark        (is_mark),
    .end_of_capture (end_of_capture),
    .busy           (busy),
    .bnd_lo         (bnd_lo),
    .bnd_hi         (bnd_hi),
    .cls_pop        (cls_pop),
    .cls            (cls),
    .cls_empty      (cls_empty)
  );

  // The sequencer consumes one classified duration per cycle whenever one is
  // queued, the result queue has room and no window rebuild is running.
  ipd_back #(
    .MAX_BITS(MAX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .cfg       (cfg),
    .cls       (cls),
    .cls_empty (cls_empty),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Finished frames wait here until the consumer pops them.
  ipd_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_DEPTH)
  ) u_result (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign frame_data   = res_out.frame_data;
  assign frame_length = res_out.frame_length;

endmodule

FILE: tb/ir_pulse_distance_decoder_tb.sv
// Self-checking testbench for the infrared pulse-distance decoder.
`timescale 1ns / 100ps

module ir_pulse_distance_decoder_tb;
  import ipd_pkg::*;

  localparam int MAX_FRAME = 64;
  localparam int SETTLE_CYCLES = 12;   // pipeline depth plus margin after the queues drain
  localparam int DRAIN_LIMIT = 20000;  // cycles allowed for one phase to drain
  localparam int LONG_HOLD = 300;      // receiver hold-off that backs the block up

  // Bit positions in the mode register.
  localparam int MODE_MSB_FIRST = 0;
  localparam int MODE_FOOT_LEAST = 1;
  localparam int MODE_SINGLE = 2;
  localparam int MODE_NO_LAST_SPACE = 3;

  // Outcome of one pass of the frame sequencer over a duration.
  localparam int STEP_MISS = -1;
  localparam int STEP_MORE = 0;
  localparam int STEP_DONE = 1;

  // Ways a well-formed frame gets broken on purpose.
  localparam int BREAK_NOISE = 0;
  localparam int BREAK_KIND = 1;
  localparam int BREAK_CUT = 2;

  typedef enum logic [2:0] {
    SEQ_HDR_MARK,
    SEQ_HDR_SPACE,
    SEQ_DATA_MARK,
    SEQ_DATA_SPACE,
    SEQ_FOOT_MARK,
    SEQ_FOOT_SPACE
  } seq_phase_e;

  typedef struct {
    logic [DUR_W-1:0] dur;
    bit               mark;
    bit               eoc;
  } dur_item_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [DUR_W-1:0]     duration = '0;
  logic                 is_mark = 1'b0;
  logic                 end_of_capture = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [DATA_W-1:0]    frame_data;
  logic [LEN_W-1:0]     frame_length;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ir_pulse_distance_decoder #(.MAX_BITS(MAX_FRAME)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .duration(duration),
    .is_mark(is_mark),
    .end_of_capture(end_of_capture),
    .empty(empty),
    .pop(pop),
    .frame_data(frame_data),
    .frame_length(frame_length),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The testbench's own copy of the configuration registers, at reset values.
  logic [31:0]        cfg_hdr = '0;
  logic [31:0]        cfg_one = '0;
  logic [31:0]        cfg_zero = '0;
  logic [31:0]        cfg_foot = '0;
  logic [6:0]         cfg_tol = 7'd25;
  logic signed [15:0] cfg_exc = '0;
  logic [6:0]         cfg_fbits = 7'd32;
  logic [3:0]         cfg_mode = 4'd1;

  // Frame sequencer state of the decoder model.
  seq_phase_e  seq_phase = SEQ_DATA_MARK;
  int unsigned seq_bits = 0;
  logic [63:0] seq_data = '0;
  logic [1:0]  seq_class = '0;

  dur_item_t pending_durations[$];
  result_t   expected_frames[$];

  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned frames_seen = 0;
  int unsigned full_stalls = 0;
  int unsigned settings_used = 0;
  int unsigned failures = 0;

  // Set once by the stimulus to end idling, and to ask for the long hold-off.
  bit calm = 1'b0;
  bit long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder model. Window bounds are recomputed per duration in 64-bit signed
  // arithmetic, which is exact for every register value the ports allow.
  // ---------------------------------------------------------------------------

  function automatic int unsigned frame_size();
    int unsigned n;
    n = 32'(cfg_fbits);
    if (n == 0) n = 1;
    if (n > MAX_FRAME) n = MAX_FRAME;
    return n;
  endfunction

  // A duration matches when it lies in [lo, hi] around the wanted time. A
  // negative wanted time counts as zero and the low bound never goes below zero.
  function automatic bit in_window(logic [15:0] meas, longint want);
    longint t, lo, hi;
    t = longint'(cfg_tol);
    if (want < 0) want = 0;
    lo = want * (100 - t) / 100;
    if (lo < 0) lo = 0;
    hi = want * (100 + t) / 100 + 1;
    return (longint'(meas) >= lo) && (longint'(meas) <= hi);
  endfunction

  // The excess offset lengthens marks and shortens spaces.
  function automatic bit mark_fits(logic [15:0] meas, logic [15:0] m);
    return in_window(meas, longint'(m) + longint'(cfg_exc));
  endfunction

  function automatic bit space_fits(logic [15:0] meas, logic [15:0] s);
    return in_window(meas, longint'(s) - longint'(cfg_exc));
  endfunction

  // An at-least footer space has no upper bound, and a zero duration passes too.
  function automatic bit long_enough(logic [15:0] meas, logic [15:0] s);
    longint t, lo;
    if (meas == 0) return 1'b1;
    t = longint'(cfg_tol);
    lo = (longint'(s) * (100 - t) - 100 * longint'(cfg_exc)) / 100;
    if (lo < 0) lo = 0;
    return longint'(meas) >= lo;
  endfunction

  // Hunting starts at the first enabled part of the header.
  function automatic void restart_frame();
    if (cfg_hdr[31:16] != 0) seq_phase = SEQ_HDR_MARK;
    else if (cfg_hdr[15:0] != 0) seq_phase = SEQ_HDR_SPACE;
    else seq_phase = SEQ_DATA_MARK;
    seq_bits = 0;
    seq_data = '0;
    seq_class = '0;
  endfunction

  function automatic bit trailing_space_due();
    if (cfg_mode[MODE_NO_LAST_SPACE]) return 1'b0;
    return (cfg_foot[31:16] != 0) || (cfg_one[15:0] != cfg_zero[15:0]);
  endfunction

  function automatic void shift_in(bit b);
    if (cfg_mode[MODE_MSB_FIRST]) seq_data = {seq_data[62:0], b};
    else seq_data = seq_data | (64'(b) << (seq_bits % 64));
    seq_bits++;
  endfunction

  // The footer space is skipped when it is disabled or the capture just ended.
  function automatic int after_foot_mark(bit eoc);
    if (cfg_foot[15:0] != 0 && !eoc) begin
      seq_phase = SEQ_FOOT_SPACE;
      return STEP_MORE;
    end
    return STEP_DONE;
  endfunction

  function automatic int after_data(bit eoc);
    if (cfg_foot[31:16] != 0) begin
      seq_phase = SEQ_FOOT_MARK;
      return STEP_MORE;
    end
    return after_foot_mark(eoc);
  endfunction

  function automatic int advance(logic [15:0] dur, bit mk, bit eoc);
    int unsigned n;
    bit tail_mark, want_mark, use_mark;
    logic [1:0] hits;
    n = frame_size();
    tail_mark = (seq_bits + 1 == n) && !trailing_space_due();
    case (seq_phase)
      SEQ_HDR_MARK: begin
        if (!mk || !mark_fits(dur, cfg_hdr[31:16])) return STEP_MISS;
        seq_phase = (cfg_hdr[15:0] != 0) ? SEQ_HDR_SPACE : SEQ_DATA_MARK;
        return STEP_MORE;
      end
      SEQ_HDR_SPACE: begin
        if (mk || !space_fits(dur, cfg_hdr[15:0])) return STEP_MISS;
        seq_phase = SEQ_DATA_MARK;
        return STEP_MORE;
      end
      SEQ_DATA_MARK: begin
        if (cfg_mode[MODE_SINGLE]) begin
          // Every duration is a bit; even bits are marks, odd bits spaces. A
          // last bit without trailing space is timed as a mark either way.
          want_mark = (seq_bits % 2) == 0;
          use_mark = want_mark || tail_mark;
          if (mk != want_mark) return STEP_MISS;
          if (use_mark ? mark_fits(dur, cfg_one[31:16]) : space_fits(dur, cfg_one[15:0]))
            shift_in(1'b1);
          else if (use_mark ? mark_fits(dur, cfg_zero[31:16])
                            : space_fits(dur, cfg_zero[15:0]))
            shift_in(1'b0);
          else
            return STEP_MISS;
          if (seq_bits >= n) return after_data(eoc);
          return STEP_MORE;
        end
        if (!mk) return STEP_MISS;
        hits = {mark_fits(dur, cfg_zero[31:16]), mark_fits(dur, cfg_one[31:16])};
        if (hits == 0) return STEP_MISS;
        if (tail_mark) begin
          shift_in(hits[0]);
          return after_data(eoc);
        end
        seq_class = hits;
        seq_phase = SEQ_DATA_SPACE;
        return STEP_MORE;
      end
      SEQ_DATA_SPACE: begin
        if (mk) return STEP_MISS;
        if (seq_class[0] && space_fits(dur, cfg_one[15:0])) shift_in(1'b1);
        else if (seq_class[1] && space_fits(dur, cfg_zero[15:0])) shift_in(1'b0);
        else return STEP_MISS;
        seq_class = '0;
        if (seq_bits >= n) return after_data(eoc);
        seq_phase = SEQ_DATA_MARK;
        return STEP_MORE;
      end
      SEQ_FOOT_MARK: begin
        if (!mk || !mark_fits(dur, cfg_foot[31:16])) return STEP_MISS;
        return after_foot_mark(eoc);
      end
      SEQ_FOOT_SPACE: begin
        if (mk) return STEP_MISS;
        if (cfg_mode[MODE_FOOT_LEAST]) begin
          if (!long_enough(dur, cfg_foot[15:0])) return STEP_MISS;
        end else if (!space_fits(dur, cfg_foot[15:0])) begin
          return STEP_MISS;
        end
        return STEP_DONE;
      end
      default: return STEP_MISS;
    endcase
  endfunction

  // Runs one accepted duration through the model and queues the frame it
  // completes, if any. A mark that breaks a frame gets one more look as the
  // start of a new frame, unless it was already evaluated from the hunting state.
  function automatic void decode_item(dur_item_t it);
    seq_phase_e ph0;
    int unsigned b0, n;
    int r;
    bit again;
    result_t fr;
    ph0 = seq_phase;
    b0 = seq_bits;
    do begin
      again = 1'b0;
      r = advance(it.dur, it.mark, it.eoc);
      if (r == STEP_MISS) begin
        restart_frame();
        if (it.mark && !(ph0 == seq_phase && b0 == 0)) begin
          ph0 = seq_phase;
          b0 = 0;
          again = 1'b1;
        end
      end
    end while (again);
    if (r == STEP_DONE) begin
      n = frame_size();
      fr.frame_length = LEN_W'(n);
      fr.frame_data = (n >= 64) ? seq_data : (seq_data & ((64'd1 << n) - 64'd1));
      expected_frames = {expected_frames, fr};
      restart_frame();
    end
    if (it.eoc) restart_frame();
  endfunction

  // Mirrors a register write into the model; every write restarts hunting.
  function automatic void load_reg(reg_idx_t idx, logic [31:0] v);
    case (idx)
      REG_HEADER:     cfg_hdr = v;
      REG_ONE:        cfg_one = v;
      REG_ZERO:       cfg_zero = v;
      REG_FOOTER:     cfg_foot = v;
      REG_TOLERANCE:  cfg_tol = v[6:0];
      REG_EXCESS:     cfg_exc = v[15:0];
      REG_FRAME_BITS: cfg_fbits = v[6:0];
      REG_MODE:       cfg_mode = v[3:0];
      default: ;
    endcase
    restart_frame();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. An item is accepted at an edge where push is high and full is
  // low, so the model sees it at that same edge. While full holds the item off,
  // the driver keeps it steady. Otherwise it may idle for a burst of cycles
  // before it offers the next item.
  // ---------------------------------------------------------------------------
  dur_item_t   cur_item;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_item(cur_item);
        items_taken++;
      end
      if (push && full) begin
        full_stalls++;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        gap_left = $urandom_range(0, 7);
        push <= 1'b0;
      end else if (pending_durations.size() > 0) begin
        cur_item = pending_durations.pop_front();
        duration <= cur_item.dur;
        is_mark <= cur_item.mark;
        end_of_capture <= cur_item.eoc;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. Every transfer is compared field by field with the oldest
  // expected frame. Pop idles in random bursts, and once, on request, it holds
  // off for a long stretch so that the block backs up and raises full.
  // ---------------------------------------------------------------------------
  result_t     want_frame;
  int unsigned hold_left = 0;
  bit          long_hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        frames_seen++;
        if (expected_frames.size() == 0) begin
          $error("frame transfer with nothing expected: frame_data %h, frame_length %0d",
                 frame_data, frame_length);
          failures++;
        end else begin
          want_frame = expected_frames.pop_front();
          if (frame_data !== want_frame.frame_data) begin
            $error("frame_data mismatch: expected %h, actual %h",
                   want_frame.frame_data, frame_data);
            failures++;
          end
          if (frame_length !== want_frame.frame_length) begin
            $error("frame_length mismatch: expected %0d, actual %0d",
                   want_frame.frame_length, frame_length);
            failures++;
          end
        end
      end
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        hold_left = LONG_HOLD;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        hold_left = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  function automatic dur_item_t make_item(logic [15:0] dur, bit mk);
    dur_item_t it;
    it.dur = dur;
    it.mark = mk;
    it.eoc = 1'b0;
    return it;
  endfunction

  function automatic void queue_item(dur_item_t it);
    pending_durations = {pending_durations, it};
    items_queued++;
  endfunction

  // Picks a duration near the wanted time, mostly inside the tolerance window.
  function automatic logic [15:0] close_to(longint want);
    longint spread, v;
    if (want < 0) want = 0;
    if (want > 65535) want = 65535;
    spread = want * longint'(cfg_tol) / 300;
    v = want - spread + longint'($urandom_range(0, 32'(2 * spread)));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [15:0] mark_dur(logic [15:0] m);
    return close_to(longint'(m) + longint'(cfg_exc));
  endfunction

  function automatic logic [15:0] space_dur(logic [15:0] s);
    return close_to(longint'(s) - longint'(cfg_exc));
  endfunction

  // Builds one frame that follows the current settings, with random data.
  // Some frames end the capture early, skip the footer space or get broken.
  function automatic void queue_frame();
    dur_item_t frm[$];
    dur_item_t it;
    int n, idx;
    bit b, tail_mark, skip_space;
    n = frame_size();
    if (cfg_hdr[31:16] != 0) frm = {frm, make_item(mark_dur(cfg_hdr[31:16]), 1'b1)};
    if (cfg_hdr[15:0] != 0) frm = {frm, make_item(space_dur(cfg_hdr[15:0]), 1'b0)};
    for (int i = 0; i < n; i++) begin
      b = 1'($urandom_range(0, 1));
      tail_mark = (i == n - 1) && !trailing_space_due();
      if (cfg_mode[MODE_SINGLE]) begin
        if ((i % 2 == 0) || tail_mark)
          frm = {frm, make_item(mark_dur(b ? cfg_one[31:16] : cfg_zero[31:16]), i % 2 == 0)};
        else
          frm = {frm, make_item(space_dur(b ? cfg_one[15:0] : cfg_zero[15:0]), 1'b0)};
      end else begin
        frm = {frm, make_item(mark_dur(b ? cfg_one[31:16] : cfg_zero[31:16]), 1'b1)};
        if (!tail_mark)
          frm = {frm, make_item(space_dur(b ? cfg_one[15:0] : cfg_zero[15:0]), 1'b0)};
      end
    end
    if (cfg_foot[31:16] != 0) frm = {frm, make_item(mark_dur(cfg_foot[31:16]), 1'b1)};
    skip_space = ($urandom_range(0, 3) == 0);
    if (cfg_foot[15:0] != 0 && !skip_space) begin
      if (!cfg_mode[MODE_FOOT_LEAST])
        frm = {frm, make_item(space_dur(cfg_foot[15:0]), 1'b0)};
      else if ($urandom_range(0, 4) == 0)
        frm = {frm, make_item(16'd0, 1'b0)};
      else
        frm = {frm, make_item(16'($urandom_range(cfg_foot[15:0], 65535)), 1'b0)};
    end
    it = frm[frm.size() - 1];
    it.eoc = skip_space || ($urandom_range(0, 3) == 0);
    frm[frm.size() - 1] = it;
    if ($urandom_range(0, 4) == 0) begin
      idx = $urandom_range(0, frm.size() - 1);
      it = frm[idx];
      case ($urandom_range(BREAK_NOISE, BREAK_CUT))
        BREAK_NOISE: it.dur = 16'($urandom);
        BREAK_KIND:  it.mark = !it.mark;
        default: begin
          while (frm.size() > idx + 1) void'(frm.pop_back());
          it.eoc = 1'b1;
        end
      endcase
      frm[idx] = it;
    end
    foreach (frm[i]) queue_item(frm[i]);
  endfunction

  function automatic void queue_noise();
    dur_item_t it;
    it.dur = 16'($urandom);
    it.mark = 1'($urandom_range(0, 1));
    it.eoc = ($urandom_range(0, 9) == 0);
    queue_item(it);
  endfunction

  // Mostly well-formed frames, the rest loose durations.
  function automatic void fill_phase(int unsigned budget);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < budget) begin
      if ($urandom_range(0, 9) < 8) queue_frame();
      else queue_noise();
    end
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    load_reg(idx, v);
  endtask

  // Writes all registers. Narrow registers sometimes carry junk in the unused
  // upper bits of the write data, which the block must ignore.
  task automatic write_all(logic [31:0] hdr, logic [31:0] one, logic [31:0] zero,
                           logic [31:0] foot, logic [6:0] tol, logic [15:0] exc,
                           logic [6:0] fb, logic [3:0] mode);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_reg(REG_HEADER, hdr);
    write_reg(REG_ONE, one);
    write_reg(REG_ZERO, zero);
    write_reg(REG_FOOTER, foot);
    write_reg(REG_TOLERANCE, {junk[31:7], tol});
    write_reg(REG_EXCESS, {junk[31:16], exc});
    write_reg(REG_FRAME_BITS, {junk[31:7], fb});
    write_reg(REG_MODE, {junk[31:4], mode});
    settings_used++;
  endtask

  // Random settings, with the extremes forced in chosen phases. The first
  // sixteen phases walk through every mode combination.
  task automatic setup_phase(int k);
    logic [31:0] hdr, one, zero, foot;
    logic [6:0]  tol, fb;
    logic [15:0] exc;
    logic [3:0]  mode;
    int pick;
    hdr = {16'($urandom_range(2000, 9000)), 16'($urandom_range(1000, 5000))};
    pick = $urandom_range(0, 3);
    if (pick == 0) hdr = '0;
    else if (pick == 1) hdr[15:0] = '0;
    else if (pick == 2) hdr[31:16] = '0;
    one = {16'($urandom_range(300, 1500)), 16'($urandom_range(300, 2500))};
    zero = {($urandom_range(0, 1) ? one[31:16] : 16'($urandom_range(300, 1500))),
            16'($urandom_range(300, 2500))};
    foot = {16'($urandom_range(300, 1000)), 16'($urandom_range(1000, 20000))};
    pick = $urandom_range(0, 3);
    if (pick == 0) foot = '0;
    else if (pick == 1) foot[15:0] = '0;
    else if (pick == 2) foot[31:16] = '0;
    tol = 7'($urandom_range(10, 35));
    exc = 16'($urandom_range(0, 200) - 100);
    pick = $urandom_range(0, 9);
    if (pick < 7) fb = 7'($urandom_range(1, 12));
    else if (pick < 9) fb = 7'($urandom_range(13, 32));
    else fb = 7'($urandom_range(33, 64));
    mode = (k < 16) ? 4'(k) : 4'($urandom_range(0, 15));
    case (k)
      1:  tol = 7'd0;
      2:  tol = 7'd100;
      3:  tol = 7'd127;
      4:  exc = 16'h8000;
      5:  exc = 16'h7FFF;
      6:  fb = 7'd0;
      7:  fb = 7'd64;
      8:  fb = 7'd100;
      9:  fb = 7'd1;
      10: hdr = 32'hFFFF_FFFF;
      11: begin
        one = '0;
        zero = 32'hFFFF_FFFF;
      end
      12: foot = 32'hFFFF_FFFF;
      default: ;
    endcase
    write_all(hdr, one, zero, foot, tol, exc, fb, mode);
  endtask

  // Waits until every queued duration was taken and every expected frame has
  // arrived, then lets the pipeline run empty.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while ((items_taken != items_queued || expected_frames.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    restart_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings first: zero bit timings give windows of zero to one.
    fill_phase(40);
    settle();

    // Directed part with a classic header, two data bits and a footer.
    write_all({16'd9000, 16'd4500}, {16'd560, 16'd1690}, {16'd560, 16'd560},
              {16'd560, 16'd20000}, 7'd25, 16'd0, 7'd2, 4'd1);
    // Extreme durations: a zero mark ending a capture, a full-scale space while
    // a header mark is hunted.
    queue_item('{16'd0, 1'b1, 1'b1});
    queue_item('{16'hFFFF, 1'b0, 1'b0});
    // A complete frame carrying 1 then 0, with footer mark and space.
    queue_item('{16'd9000, 1'b1, 1'b0});
    queue_item('{16'd4500, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b0});
    queue_item('{16'd1690, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b0});
    queue_item('{16'd560, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b0});
    queue_item('{16'd20000, 1'b0, 1'b0});
    // A mark of the wrong kind where the header space belongs is taken as a new
    // header mark. The capture ends on the footer mark, so the footer space is
    // skipped.
    queue_item('{16'd9000, 1'b1, 1'b0});
    queue_item('{16'd9000, 1'b1, 1'b0});
    queue_item('{16'd4500, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b0});
    queue_item('{16'd560, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b0});
    queue_item('{16'd1690, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b1});
    // End of capture in the middle of a frame drops it.
    queue_item('{16'd9000, 1'b1, 1'b0});
    queue_item('{16'd4500, 1'b0, 1'b0});
    queue_item('{16'd560, 1'b1, 1'b1});
    // A full-scale mark fails once, as a header, since hunting has already restarted.
    queue_item('{16'hFFFF, 1'b1, 1'b0});
    settle();

    for (int k = 0; k < 26; k++) begin
      if (k == 13) begin
        // One-bit frames that need no trailing space: every mark completes a
        // frame. The receiver holds off meanwhile, so results pile up and full
        // has to stall the sender.
        write_all('0, {16'd600, 16'd600}, {16'd1200, 16'd1200}, '0,
                  7'd25, 16'd0, 7'd1, 4'b1000);
        long_hold_req <= 1'b1;
        repeat (60) queue_item(make_item(mark_dur($urandom_range(0, 1) ? 16'd600 : 16'd1200),
                                         1'b1));
        settle();
      end
      if (k == 25) calm <= 1'b1;
      setup_phase(k);
      fill_phase(30);
      settle();
    end

    if (expected_frames.size() != 0) begin
      $error("%0d expected frames never arrived", expected_frames.size());
      failures += expected_frames.size();
    end
    $display("Ran %0d durations through %0d register settings; %0d frames compared.",
             items_taken, settings_used, frames_seen);
    $display("The input was held off by full for %0d cycles.", full_stalls);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
